// ===== design/section_address_translator_core_defines.svh =====
// Assertion macros used by the bound checker in sat_checker.sv.
`ifndef SECTION_ADDRESS_TRANSLATOR_CORE_DEFINES_SVH
`define SECTION_ADDRESS_TRANSLATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sat_checker: property failed");

// The consequent must hold in the cycle after the antecedent.
`define SAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sat_checker: property failed");

`endif

// ===== design/sat_pkg.sv =====
package sat_pkg;

	localparam int MAX_SECTIONS_DEF = 16;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_ALIGN = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_COUNT = 2'd1;

	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_RVA  = 2'd1;
	localparam logic [1:0] REQ_OFF  = 2'd2;

	localparam logic [31:0] ALIGN_RESET = 32'd4096;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] lookup_address;
		logic [3:0]  entry_slot;
		logic [31:0] entry_virtual_start;
		logic [31:0] entry_virtual_size;
		logic [31:0] entry_raw_start;
		logic [31:0] entry_raw_size;
	} sat_in_t;

	typedef struct packed {
		logic [31:0] translated_address;
		logic        section_hit;
		logic [3:0]  hit_slot;
	} sat_out_t;

	typedef struct packed {
		logic [31:0] virtual_start;
		logic [31:0] virtual_size;
		logic [31:0] raw_start;
		logic [31:0] raw_size;
	} sat_entry_t;

endpackage

// ===== design/sat_ram.sv =====
module sat_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/section_address_translator_core.sv =====
// Load: written to the descriptor memory at its acceptance edge if its slot is in range;
// one transfer per cycle while no lookup is in progress. Lookup: one descriptor read per
// cycle, stopping at the first slot whose end exceeds the address; the hit or miss is
// registered, then the result is offered, after any stalled earlier result has gone.
// Address zero skips the walk and misses. The next transfer can be taken once it is offered.
// Reset clears control, sets alignment to 4096 and count to zero; descriptors are kept.
module section_address_translator_core
	import sat_pkg::*;
#(
	parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  sat_in_t                in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output sat_out_t               out_data,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

	localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
	localparam int ENT_W = $bits(sat_entry_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_CALC
	} state_t;

	state_t          state_q;
	logic [31:0]     align_m1_q;
	logic [4:0]      count_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] n_c;
	logic [CNT_W-1:0] rd_idx_q;
	logic            dir_rva_q;
	logic [31:0]     addr_q;
	logic            v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic            v_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [31:0]     key_s2;
	logic [31:0]     other_s2;
	logic [31:0]     size_s2;
	logic            hit_q;
	logic [31:0]     diff_q;
	logic [31:0]     other_q;
	logic [3:0]      slot_q;
	logic            out_valid_q;
	sat_out_t        out_data_q;

	logic            in_accept;
	logic            ram_we;
	logic            ram_re;
	logic            issuing;
	sat_entry_t      ram_wdata;
	sat_entry_t      rd_entry;
	logic [ENT_W-1:0] ram_rdata;
	logic [31:0]     key_s1;
	logic [31:0]     other_s1;
	logic [31:0]     size_s1;
	logic [31:0]     end_s2;
	logic            found;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign ram_we = in_accept && (in_data.req_type == REQ_LOAD) &&
		(32'(in_data.entry_slot) < 32'(MAX_SECTIONS));
	assign ram_wdata.virtual_start = in_data.entry_virtual_start;
	assign ram_wdata.virtual_size  = in_data.entry_virtual_size;
	assign ram_wdata.raw_start     = in_data.entry_raw_start;
	assign ram_wdata.raw_size      = in_data.entry_raw_size;

	assign issuing = (rd_idx_q < n_q);
	assign ram_re  = (state_q == ST_WALK) && issuing;

	sat_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_SECTIONS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(IDX_W'(in_data.entry_slot)),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_idx_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (32'(count_q) > 32'(MAX_SECTIONS)) begin
			n_c = CNT_W'(MAX_SECTIONS);
		end else begin
			n_c = CNT_W'(count_q);
		end
	end

	always_comb begin
		rd_entry = sat_entry_t'(ram_rdata);
		if (dir_rva_q) begin
			key_s1   = rd_entry.virtual_start;
			other_s1 = rd_entry.raw_start;
			size_s1  = (rd_entry.virtual_size + align_m1_q) & ~align_m1_q;
		end else begin
			key_s1   = rd_entry.raw_start;
			other_s1 = rd_entry.virtual_start;
			size_s1  = rd_entry.raw_size;
		end
	end

	assign end_s2 = key_s2 + size_s2;
	assign found  = v_s2 && (addr_q < end_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_m1_q <= ALIGN_RESET - 32'd1;
			count_q    <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ALIGN: align_m1_q <= cfg_wr_data - 32'd1;
				CFG_COUNT: count_q    <= cfg_wr_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= rd_idx_q[IDX_W-1:0];
		idx_s2   <= idx_s1;
		key_s2   <= key_s1;
		other_s2 <= other_s1;
		size_s2  <= size_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= '0;
			n_q         <= '0;
			dir_rva_q   <= 1'b0;
			addr_q      <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			hit_q       <= 1'b0;
			diff_q      <= '0;
			other_q     <= '0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_CALC)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept && ((in_data.req_type == REQ_RVA) ||
						(in_data.req_type == REQ_OFF))) begin
						dir_rva_q <= (in_data.req_type == REQ_RVA);
						addr_q    <= in_data.lookup_address;
						rd_idx_q  <= '0;
						n_q       <= n_c;
						if (in_data.lookup_address == 32'd0) begin
							hit_q   <= 1'b0;
							state_q <= ST_CALC;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					v_s1 <= issuing && !found;
					v_s2 <= v_s1 && !found;
					if (issuing && !found) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (found) begin
						hit_q   <= !(addr_q < key_s2);
						diff_q  <= addr_q - key_s2;
						other_q <= other_s2;
						slot_q  <= 4'(idx_s2);
						state_q <= ST_CALC;
					end else if (!issuing && !v_s1 && !v_s2) begin
						hit_q   <= 1'b0;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						if (hit_q) begin
							out_data_q.translated_address <= diff_q + other_q;
							out_data_q.hit_slot           <= slot_q;
						end else begin
							out_data_q.translated_address <= dir_rva_q ? addr_q : 32'd0;
							out_data_q.hit_slot           <= 4'd0;
						end
						out_data_q.section_hit <= hit_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/sat_checker.sv =====
`include "section_address_translator_core_defines.svh"

module sat_checker
	import sat_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_stall,
	input sat_in_t  in_data,
	input logic     out_valid,
	input logic     out_stall,
	input sat_out_t out_data
);

	// A stalled result stays in place until it is transferred.
	`SAT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))

	// A miss never reports a slot.
	`SAT_ASSERT_SAME(a_miss_slot, clk, arst_n, out_valid && !out_data.section_hit, out_data.hit_slot == 4'd0)

	// A transfer that is not a lookup produces no new result in the next cycle.
	`SAT_ASSERT_NEXT(a_load_silent, clk, arst_n, in_valid && !in_stall && (in_data.req_type != REQ_RVA) && (in_data.req_type != REQ_OFF), !$rose(out_valid))

endmodule

bind section_address_translator_core sat_checker u_sat_checker (.*);

// ===== verif/section_address_translator_checker.sv =====
// Watches both channels and the register port, keeps its own copy of the descriptor
// table and the registers, and compares every result transfer with the oldest
// outstanding prediction.
module section_address_translator_checker
	import sat_pkg::*;
#(
	parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  sat_in_t                in_data,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  sat_out_t               out_data,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
	output int                     failures,
	output int                     outstanding
);

	sat_entry_t  descriptors [MAX_SECTIONS];
	logic [31:0] alignment;
	logic [4:0]  section_count;
	sat_out_t    pending_results [$];
	int          error_total;

	function automatic sat_out_t translate(sat_in_t req);
		sat_out_t    res;
		logic [31:0] lo;
		logic [31:0] hi;
		int          limit;
		bit          found;
		res = '0;
		found = 1'b0;
		limit = (section_count > MAX_SECTIONS) ? MAX_SECTIONS : int'(section_count);
		if (req.lookup_address == 32'd0) begin
			return res;
		end
		if (req.req_type == REQ_RVA) begin
			res.translated_address = req.lookup_address;
		end
		for (int i = 0; i < limit && !found; i++) begin
			if (req.req_type == REQ_RVA) begin
				lo = descriptors[i].virtual_start;
				hi = lo + ((descriptors[i].virtual_size + alignment - 32'd1) &
					~(alignment - 32'd1));
			end else begin
				lo = descriptors[i].raw_start;
				hi = lo + descriptors[i].raw_size;
			end
			if (req.lookup_address < hi) begin
				found = 1'b1;
				if (req.lookup_address >= lo) begin
					res.section_hit = 1'b1;
					res.hit_slot = i[3:0];
					if (req.req_type == REQ_RVA) begin
						res.translated_address = req.lookup_address -
							descriptors[i].virtual_start + descriptors[i].raw_start;
					end else begin
						res.translated_address = req.lookup_address -
							descriptors[i].raw_start + descriptors[i].virtual_start;
					end
				end
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sat_out_t want;
		if (!arst_n) begin
			alignment = ALIGN_RESET;
			section_count = 5'd0;
			pending_results.delete();
			error_total = 0;
			failures <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result transfer with no lookup outstanding: %h", out_data);
					error_total++;
				end else begin
					want = pending_results.pop_front();
					if (out_data.translated_address !== want.translated_address) begin
						$error("translated_address: expected %h, got %h",
							want.translated_address, out_data.translated_address);
						error_total++;
					end
					if (out_data.section_hit !== want.section_hit) begin
						$error("section_hit: expected %b, got %b",
							want.section_hit, out_data.section_hit);
						error_total++;
					end
					if (out_data.hit_slot !== want.hit_slot) begin
						$error("hit_slot: expected %0d, got %0d",
							want.hit_slot, out_data.hit_slot);
						error_total++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				case (in_data.req_type)
					REQ_LOAD: begin
						if (in_data.entry_slot < MAX_SECTIONS) begin
							descriptors[in_data.entry_slot] = '{
								virtual_start: in_data.entry_virtual_start,
								virtual_size:  in_data.entry_virtual_size,
								raw_start:     in_data.entry_raw_start,
								raw_size:      in_data.entry_raw_size
							};
						end
					end
					REQ_RVA, REQ_OFF: begin
						pending_results.push_back(translate(in_data));
					end
					default: begin
					end
				endcase
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_ALIGN: begin
						alignment = cfg_wr_data[31:0];
					end
					CFG_COUNT: begin
						section_count = cfg_wr_data[4:0];
					end
					default: begin
					end
				endcase
			end
			failures <= error_total;
			outstanding <= pending_results.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
module tb;
	import sat_pkg::*;

	localparam logic [1:0]             REQ_IGNORED = 2'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam int NUM_PHASES   = 12;
	localparam int PHASE_ITEMS  = 26;
	localparam int SETTLE_WAIT  = 32;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 600000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	sat_in_t                in_data = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	sat_out_t               out_data;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

	int failures;
	int outstanding;
	int cycle_count = 0;
	bit quiet = 1'b0;
	bit hold_request = 1'b0;
	int active = 0;

	logic [31:0] lay_vs [16];
	logic [31:0] lay_vsz [16];
	logic [31:0] lay_rs [16];
	logic [31:0] lay_rsz [16];

	section_address_translator_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data)
	);

	section_address_translator_checker audit (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.failures    (failures),
		.outstanding (outstanding)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL section_address_translator_core");
			$finish;
		end
	end

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic sat_in_t noise_item();
		sat_in_t item;
		item.req_type = 2'($urandom);
		item.lookup_address = $urandom;
		item.entry_slot = 4'($urandom);
		item.entry_virtual_start = $urandom;
		item.entry_virtual_size = $urandom;
		item.entry_raw_start = $urandom;
		item.entry_raw_size = $urandom;
		return item;
	endfunction

	function automatic logic [31:0] pick_inside(logic [31:0] start, logic [31:0] size);
		if (size == 32'd0) begin
			return start;
		end
		return start + $urandom_range(0, size - 32'd1);
	endfunction

	task automatic send(input sat_in_t item);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic lookup(input logic [1:0] kind, input logic [31:0] addr);
		sat_in_t item;
		item = noise_item();
		item.req_type = kind;
		item.lookup_address = addr;
		send(item);
	endtask

	task automatic load_slot(input int slot, input logic [31:0] vs, input logic [31:0] vsz,
			input logic [31:0] rs, input logic [31:0] rsz);
		sat_in_t item;
		item = noise_item();
		item.req_type = REQ_LOAD;
		item.entry_slot = slot[3:0];
		item.entry_virtual_start = vs;
		item.entry_virtual_size = vsz;
		item.entry_raw_start = rs;
		item.entry_raw_size = rsz;
		lay_vs[slot] = vs;
		lay_vsz[slot] = vsz;
		lay_rs[slot] = rs;
		lay_rsz[slot] = rsz;
		send(item);
	endtask

	// Ascending sections, as a linker lays them out; the last one may wrap past 2^32.
	task automatic build_layout(input int n, input bit wrap_last);
		logic [31:0] vnext;
		logic [31:0] rnext;
		logic [31:0] vsz;
		logic [31:0] rsz;
		vnext = 32'h1000 * $urandom_range(1, 16);
		rnext = 32'h200 * $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			vsz = $urandom_range(1, 32'h8000);
			rsz = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, vsz);
			if (wrap_last && i == n - 1) begin
				load_slot(i, 32'hFFFF_F000, 32'h3000, 32'hFFFF_FE00, 32'h800);
			end else begin
				load_slot(i, vnext, vsz, rnext, rsz);
			end
			vnext += ((vsz + 32'hFFF) & ~32'hFFF) + 32'h1000 * $urandom_range(0, 2);
			rnext += (rsz + 32'h1FF) & ~32'h1FF;
		end
		active = n;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic boundary_lookup();
		logic [1:0]  kind;
		logic [31:0] start;
		logic [31:0] size;
		int          j;
		kind = $urandom_range(0, 1) ? REQ_RVA : REQ_OFF;
		j = $urandom_range(0, active - 1);
		start = (kind == REQ_RVA) ? lay_vs[j] : lay_rs[j];
		size = (kind == REQ_RVA) ? lay_vsz[j] : lay_rsz[j];
		case ($urandom_range(0, 3))
			0: lookup(kind, start);
			1: lookup(kind, start - 32'd1);
			2: lookup(kind, start + size - 32'd1);
			default: lookup(kind, start + size);
		endcase
	endtask

	task automatic random_phase(input int phase);
		logic [31:0] align_value;
		logic [31:0] count_value;
		sat_in_t     item;
		int          r;
		int          j;
		settle();
		r = $urandom_range(0, 99);
		if (r < 70) begin
			align_value = 32'd1 << $urandom_range(9, 12);
		end else if (r < 90) begin
			align_value = 32'd1 << $urandom_range(0, 31);
		end else begin
			align_value = $urandom_range(1, 32'hFFFF);
		end
		r = $urandom_range(0, 99);
		if (r < 70) begin
			count_value = $urandom_range(1, 16);
		end else if (r < 85) begin
			count_value = 32'd0;
		end else begin
			count_value = $urandom_range(17, 31);
		end
		write_reg(CFG_ALIGN, align_value);
		write_reg(CFG_COUNT, count_value);
		if ($urandom_range(0, 3) == 0) begin
			write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
		end
		quiet = (phase % 4 == 1);
		build_layout((count_value == 0) ? $urandom_range(1, 16)
			: ((count_value > 16) ? 16 : count_value), $urandom_range(0, 5) == 0);
		if (phase == 2) begin
			hold_request <= 1'b1;
		end
		for (int k = 0; k < PHASE_ITEMS; k++) begin
			r = $urandom_range(0, 99);
			j = $urandom_range(0, active - 1);
			if (r < 40) begin
				lookup(REQ_RVA, pick_inside(lay_vs[j], lay_vsz[j]));
			end else if (r < 70) begin
				lookup(REQ_OFF, pick_inside(lay_rs[j], lay_rsz[j]));
			end else if (r < 78) begin
				boundary_lookup();
			end else if (r < 86) begin
				lookup($urandom_range(0, 1) ? REQ_RVA : REQ_OFF, $urandom);
			end else if (r < 92) begin
				load_slot($urandom_range(0, 15), $urandom, $urandom, $urandom, $urandom);
			end else if (r < 96) begin
				item = noise_item();
				item.req_type = REQ_IGNORED;
				send(item);
			end else begin
				lookup($urandom_range(0, 1) ? REQ_RVA : REQ_OFF, 32'd0);
			end
		end
	endtask

	initial begin
		int  run;
		int  r;
		bit  level;
		bit  hold_served;
		hold_served = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request && !hold_served) begin
				hold_served = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					level = 1'b0;
					run = $urandom_range(40, 150);
				end else if (r < 20) begin
					level = 1'b1;
					run = $urandom_range(8, 40);
				end else begin
					level = ($urandom_range(0, 99) < 35);
					run = $urandom_range(1, 4);
				end
				repeat (run) begin
					out_stall <= level;
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		sat_in_t item;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With no sections searched every lookup misses.
		lookup(REQ_RVA, 32'hFFFF_FFFF);
		lookup(REQ_OFF, 32'hFFFF_FFFF);
		build_layout(16, 1'b1);
		settle();
		write_reg(CFG_COUNT, 32'd16);
		lookup(REQ_RVA, 32'd0);
		lookup(REQ_OFF, 32'd0);
		lookup(REQ_RVA, lay_vs[0]);
		lookup(REQ_RVA, lay_vs[0] - 32'd1);
		lookup(REQ_OFF, lay_rs[2]);
		lookup(REQ_OFF, 32'hFFFF_FFFF);
		lookup(REQ_RVA, 32'hFFFF_F800);
		item = noise_item();
		item.req_type = REQ_IGNORED;
		send(item);

		settle();
		write_reg(CFG_ALIGN, 32'd1);
		write_reg(CFG_COUNT, 32'd31);
		write_reg(CFG_SPARE_A, $urandom);
		write_reg(CFG_SPARE_B, $urandom);
		lookup(REQ_RVA, lay_vs[5] + lay_vsz[5]);
		lookup(REQ_OFF, lay_rs[15] + 32'h10);

		settle();
		write_reg(CFG_ALIGN, 32'h8000_0000);
		write_reg(CFG_COUNT, 32'd16);
		lookup(REQ_RVA, lay_vs[3]);
		lookup(REQ_RVA, 32'h8000_0000);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			random_phase(phase);
		end

		settle();
		if (failures == 0) begin
			$display("PASS section_address_translator_core");
		end else begin
			$display("FAIL section_address_translator_core");
		end
		$finish;
	end

endmodule
